/* rtl/rpt_pkg.sv */
// ----------------------------------------------------------------------------
// rpt_pkg
// Shared types and constants of the radix page table walker: field widths,
// opcodes, status codes, walker states and the result record.
// ----------------------------------------------------------------------------
package rpt_pkg;

    // Field widths of one request and one result
    localparam int OP_W     = 2;
    localparam int VPN_W    = 45;
    localparam int PPN_W    = 52;
    localparam int STATUS_W = 2;
    localparam int ROOT_W   = 6;

    // Stored entry: page number above a valid bit
    localparam int ENTRY_W  = PPN_W + 1;

    // Stream payload widths, padded to whole bytes
    localparam int IN_DATA_W  = ((VPN_W + PPN_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((PPN_W + 7) / 8) * 8;

    // Request opcodes
    localparam logic [OP_W-1:0] OP_QUERY = 2'd0;
    localparam logic [OP_W-1:0] OP_MAP   = 2'd1;
    localparam logic [OP_W-1:0] OP_UNMAP = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NO_MAP   = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NO_FRAME = 2'd2;

    // Walker sequencer states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_WALK,
        S_ZERO,
        S_LINK,
        S_DONE
    } walk_state_t;

    // One finished result
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PPN_W-1:0]    found_ppn;
    } result_t;

endpackage

/* rtl/rpt_table_mem.sv */
// ----------------------------------------------------------------------------
// rpt_table_mem
// Single-port-write, single-port-read synchronous RAM holding the page table
// frames. Read data is registered and appears in the cycle after the address.
// ----------------------------------------------------------------------------
module rpt_table_mem #(
    parameter int DEPTH  = 32768,
    parameter int ADDR_W = 15,
    parameter int DATA_W = 53
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/rpt_walker.sv */
// ----------------------------------------------------------------------------
// rpt_walker
// Walk sequencer: clears the table after reset, walks the levels one read per
// cycle unless a map allocates and zeroes a frame, and updates the leaf entry.
// ----------------------------------------------------------------------------
module rpt_walker #(
    parameter int FRAME_COUNT = 64,
    parameter int LEVELS      = 5,
    parameter int INDEX_BITS  = 9,
    parameter int ADDR_W      = 15
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration
    input  logic                        cfg_wr_en,
    input  logic [rpt_pkg::ROOT_W-1:0]  cfg_wr_data,
    // request
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [rpt_pkg::OP_W-1:0]    in_opcode,
    input  logic [rpt_pkg::VPN_W-1:0]   in_vpn,
    input  logic [rpt_pkg::PPN_W-1:0]   in_ppn,
    // result
    output logic                        res_valid,
    input  logic                        res_ready,
    output rpt_pkg::result_t            res,
    // table memory
    output logic                        mem_we,
    output logic [ADDR_W-1:0]           mem_waddr,
    output logic [rpt_pkg::ENTRY_W-1:0] mem_wdata,
    output logic                        mem_re,
    output logic [ADDR_W-1:0]           mem_raddr,
    input  logic [rpt_pkg::ENTRY_W-1:0] mem_rdata
);
    import rpt_pkg::*;

    localparam int FRAME_W   = $clog2(FRAME_COUNT);
    localparam int LVL_W     = $clog2(LEVELS);
    localparam int IDX_TOT   = LEVELS * INDEX_BITS;
    localparam int VPN_EXT_W = (IDX_TOT > VPN_W) ? IDX_TOT : VPN_W;
    localparam int FREE_MAX  = (FRAME_COUNT > 64) ? FRAME_COUNT : 64;
    localparam int FREE_W    = $clog2(FREE_MAX + 1);
    localparam int DEPTH     = FRAME_COUNT * (2 ** INDEX_BITS);
    localparam logic [ADDR_W-1:0]     LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam logic [LVL_W-1:0]      TOP_LVL   = LVL_W'(LEVELS - 1);
    localparam logic [FREE_W-1:0]     FC_FREE   = FREE_W'(FRAME_COUNT);
    localparam logic [PPN_W-1:0]      FC_PPN    = PPN_W'(FRAME_COUNT);

    // State and working registers
    walk_state_t          state_reg, state_next;
    logic [OP_W-1:0]      op_reg, op_next;
    logic [IDX_TOT-1:0]   vpn_reg, vpn_next;
    logic [PPN_W-1:0]     ppn_reg, ppn_next;
    logic [FRAME_W-1:0]   frame_reg, frame_next;
    logic [ADDR_W-1:0]    addr_reg, addr_next;
    logic [LVL_W-1:0]     depth_reg, depth_next;
    logic [FREE_W-1:0]    next_free_reg, next_free_next;
    logic [FRAME_W-1:0]   alloc_frame_reg, alloc_frame_next;
    logic [ADDR_W-1:0]    sweep_reg, sweep_next;
    logic [ROOT_W-1:0]    root_frame_reg;
    result_t              res_reg, res_next;

    // Decoded request and entry
    logic [VPN_EXT_W-1:0]  in_vpn_ext;
    logic [FREE_W-1:0]     root_ext;
    logic                  root_ok;
    logic                  op_ok;
    logic [LVL_W-1:0]      depth_dn;
    logic [INDEX_BITS-1:0] idx_cur;
    logic [INDEX_BITS-1:0] idx_down;
    logic [PPN_W-1:0]      ent_ppn;
    logic                  ent_v;
    logic                  link_ok;
    logic [FRAME_W-1:0]    link_frame;
    logic                  leaf;
    logic [FREE_W-1:0]     cand_frame;
    logic                  alloc_ok;
    logic                  zero_last;

    assign in_vpn_ext = VPN_EXT_W'(in_vpn);
    assign root_ext   = FREE_W'(root_frame_reg);
    assign root_ok    = root_ext < FC_FREE;
    assign op_ok      = (in_opcode == OP_QUERY) || (in_opcode == OP_MAP) ||
                        (in_opcode == OP_UNMAP);

    // Level indices, most significant index first
    assign depth_dn = depth_reg - LVL_W'(1);
    assign idx_cur  = vpn_reg[INDEX_BITS * depth_reg +: INDEX_BITS];
    assign idx_down = vpn_reg[INDEX_BITS * depth_dn +: INDEX_BITS];
    assign leaf     = (depth_reg == '0);

    // An intermediate entry links when nonzero and naming a real frame
    assign ent_ppn    = mem_rdata[ENTRY_W-1:1];
    assign ent_v      = mem_rdata[0];
    assign link_ok    = (|mem_rdata) && (ent_ppn < FC_PPN);
    assign link_frame = ent_ppn[FRAME_W-1:0];

    // Frame handout skips the current root frame
    assign cand_frame = (next_free_reg == root_ext) ? next_free_reg + FREE_W'(1)
                                                    : next_free_reg;
    assign alloc_ok   = cand_frame < FC_FREE;
    assign zero_last  = (sweep_reg[INDEX_BITS-1:0] == {INDEX_BITS{1'b1}});

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            next_free_reg  <= '0;
            sweep_reg      <= '0;
            root_frame_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            next_free_reg <= next_free_next;
            sweep_reg     <= sweep_next;
            if (cfg_wr_en)
            begin
                root_frame_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        vpn_reg         <= vpn_next;
        ppn_reg         <= ppn_next;
        frame_reg       <= frame_next;
        addr_reg        <= addr_next;
        depth_reg       <= depth_next;
        alloc_frame_reg <= alloc_frame_next;
        res_reg         <= res_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (sweep_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (op_ok && root_ok) ? S_LOOKUP : S_DONE;
                end
            end
            S_LOOKUP:
            begin
                state_next = S_WALK;
            end
            S_WALK:
            begin
                if (leaf)
                begin
                    state_next = S_DONE;
                end
                else if (link_ok)
                begin
                    state_next = S_WALK;
                end
                else if ((op_reg == OP_MAP) && alloc_ok)
                begin
                    state_next = S_ZERO;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_ZERO:
            begin
                if (zero_last)
                begin
                    state_next = S_LINK;
                end
            end
            S_LINK:
            begin
                state_next = S_LOOKUP;
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // Datapath, memory access and handshake outputs
    always_comb
    begin
        op_next          = op_reg;
        vpn_next         = vpn_reg;
        ppn_next         = ppn_reg;
        frame_next       = frame_reg;
        addr_next        = addr_reg;
        depth_next       = depth_reg;
        next_free_next   = next_free_reg;
        alloc_frame_next = alloc_frame_reg;
        sweep_next       = sweep_reg;
        res_next         = res_reg;
        mem_we           = 1'b0;
        mem_waddr        = addr_reg;
        mem_wdata        = '0;
        mem_re           = 1'b0;
        mem_raddr        = {frame_reg, idx_cur};
        in_ready         = (state_reg == S_IDLE);
        res_valid        = (state_reg == S_DONE);

        case (state_reg)
            S_CLEAR:
            begin
                // wipe the whole table, one entry a cycle
                mem_we     = 1'b1;
                mem_waddr  = sweep_reg;
                sweep_next = sweep_reg + ADDR_W'(1);
            end
            S_IDLE:
            begin
                // capture the request and start at the root frame
                if (in_valid)
                begin
                    op_next    = in_opcode;
                    vpn_next   = in_vpn_ext[IDX_TOT-1:0];
                    ppn_next   = in_ppn;
                    frame_next = root_ext[FRAME_W-1:0];
                    depth_next = TOP_LVL;
                    res_next.found_ppn = '0;
                    res_next.status    = (op_ok && (in_opcode == OP_MAP)) ? STAT_NO_FRAME
                                                                          : STAT_NO_MAP;
                end
            end
            S_LOOKUP:
            begin
                mem_re    = 1'b1;
                mem_raddr = {frame_reg, idx_cur};
                addr_next = {frame_reg, idx_cur};
            end
            S_WALK:
            begin
                res_next.found_ppn = '0;
                res_next.status    = STAT_NO_MAP;
                if (leaf)
                begin
                    case (op_reg)
                        OP_QUERY:
                        begin
                            if (ent_v)
                            begin
                                res_next.status    = STAT_OK;
                                res_next.found_ppn = ent_ppn;
                            end
                        end
                        OP_UNMAP:
                        begin
                            if (ent_v)
                            begin
                                mem_we          = 1'b1;
                                mem_wdata       = {ent_ppn, 1'b0};
                                res_next.status = STAT_OK;
                            end
                        end
                        OP_MAP:
                        begin
                            mem_we          = 1'b1;
                            mem_wdata       = {ppn_reg, 1'b1};
                            res_next.status = STAT_OK;
                        end
                        default:
                        begin
                            res_next.status = STAT_NO_MAP;
                        end
                    endcase
                end
                else if (link_ok)
                begin
                    // follow the link, issuing the next level read now
                    mem_re     = 1'b1;
                    mem_raddr  = {link_frame, idx_down};
                    addr_next  = {link_frame, idx_down};
                    depth_next = depth_dn;
                end
                else if (op_reg == OP_MAP)
                begin
                    // take a frame; the counter advances past the root even on failure
                    next_free_next = alloc_ok ? cand_frame + FREE_W'(1) : cand_frame;
                    if (alloc_ok)
                    begin
                        alloc_frame_next = cand_frame[FRAME_W-1:0];
                        sweep_next       = '0;
                    end
                    else
                    begin
                        res_next.status = STAT_NO_FRAME;
                    end
                end
            end
            S_ZERO:
            begin
                // zero the new frame before it is linked
                mem_we     = 1'b1;
                mem_waddr  = {alloc_frame_reg, sweep_reg[INDEX_BITS-1:0]};
                sweep_next = sweep_reg + ADDR_W'(1);
            end
            S_LINK:
            begin
                // link the new frame and descend into it
                mem_we     = 1'b1;
                mem_wdata  = {PPN_W'(alloc_frame_reg), 1'b1};
                frame_next = alloc_frame_reg;
                depth_next = depth_dn;
            end
            S_DONE:
            begin
                res_next = res_reg;
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    assign res = res_reg;

    // No table write while waiting for a request
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !mem_we)
        else $error("table written while idle");

    // The frame counter only moves upward
    assert property (@(posedge clk) disable iff (!rst_n)
        (next_free_reg != $past(next_free_reg)) |-> (next_free_reg > $past(next_free_reg)))
        else $error("frame counter moved backward");

    // A frame being zeroed exists
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ZERO) |-> (FREE_W'(alloc_frame_reg) < FC_FREE))
        else $error("zeroing a frame beyond the table");

    // Every write stays inside the table
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (mem_waddr <= LAST_ADDR))
        else $error("table write out of range");

endmodule

/* rtl/radix_page_table_walker_top.sv */
// ----------------------------------------------------------------------------
// radix_page_table_walker_top
// Radix page table walker with the table held in an internal RAM.
//
// Requests arrive on the s_axis channel (tuser = opcode: query, map, unmap;
// tdata = vpn and ppn) and one result per request leaves on m_axis
// (tuser = status, tdata = found ppn). cfg_wr_en/cfg_wr_data set the root
// frame; the user must write them only while no request is in flight, which
// the block itself does not enforce. A request walks one level per cycle
// through the table RAM, whose read data is registered, unless a frame is
// allocated. A walk without allocation runs a lookup read and one walk step
// per level; then the done state loads the result into the output register
// and returns to idle, so no request is accepted before the last one is
// finished. Each frame that a map allocates adds a zeroing sweep of its
// 2^INDEX_BITS entries, the link write and the re-read. Requests that fail
// at a missing link, bad opcode or bad root finish early. After reset all
// FRAME_COUNT * 2^INDEX_BITS entries (32768) of the RAM are swept to zero
// while s_axis_tready stays low; configuration writes are taken. The result
// sits in an output register: while the receiver stalls it holds, one more
// result may finish behind it, and then the walker waits.
// ----------------------------------------------------------------------------
module radix_page_table_walker_top #(
    parameter int FRAME_COUNT = 64,
    parameter int LEVELS      = 5,
    parameter int INDEX_BITS  = 9
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration: root_frame
    input  logic                           cfg_wr_en,
    input  logic [rpt_pkg::ROOT_W-1:0]     cfg_wr_data,
    // request stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [rpt_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // vpn[44:0], ppn[96:45], zero pad
    input  logic [rpt_pkg::OP_W-1:0]       s_axis_tuser,  // opcode[1:0]
    // result stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [rpt_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // found_ppn[51:0], zero pad
    output logic [rpt_pkg::STATUS_W-1:0]   m_axis_tuser   // status[1:0]
);
    import rpt_pkg::*;

    localparam int FRAME_W = $clog2(FRAME_COUNT);
    localparam int ADDR_W  = FRAME_W + INDEX_BITS;
    localparam int DEPTH   = FRAME_COUNT * (2 ** INDEX_BITS);

    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    logic [ENTRY_W-1:0]   mem_wdata;
    logic                 mem_re;
    logic [ADDR_W-1:0]    mem_raddr;
    logic [ENTRY_W-1:0]   mem_rdata;

    logic                 res_valid;
    logic                 res_ready;
    result_t              res;

    logic                 out_valid_reg;
    result_t              out_reg;

    // Table memory
    rpt_table_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (ENTRY_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Walk sequencer
    rpt_walker #(
        .FRAME_COUNT (FRAME_COUNT),
        .LEVELS      (LEVELS),
        .INDEX_BITS  (INDEX_BITS),
        .ADDR_W      (ADDR_W)
    ) u_walker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_opcode   (s_axis_tuser),
        .in_vpn      (s_axis_tdata[VPN_W-1:0]),
        .in_ppn      (s_axis_tdata[VPN_W+PPN_W-1:VPN_W]),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_re      (mem_re),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata)
    );

    // Output register: load when empty or being drained
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Hold result payload until the transfer
    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.status;
    assign m_axis_tdata  = OUT_DATA_W'(out_reg.found_ppn);

endmodule

/* sim/rpt_walk_checker.sv */
// ----------------------------------------------------------------------------
// rpt_walk_checker
// Watches the request, result and configuration ports of the page table
// walker. It keeps its own copy of the table memory, the frame counter and the
// root frame, predicts the result of every accepted request and compares each
// accepted result against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module rpt_walk_checker #(
    parameter int FRAME_COUNT = 64,
    parameter int LEVELS      = 5,
    parameter int INDEX_BITS  = 9
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [rpt_pkg::ROOT_W-1:0]     cfg_wr_data,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    input  logic [rpt_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // vpn[44:0], ppn[96:45], zero pad
    input  logic [rpt_pkg::OP_W-1:0]       s_axis_tuser,  // opcode[1:0]
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [rpt_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // found_ppn[51:0], zero pad
    input  logic [rpt_pkg::STATUS_W-1:0]   m_axis_tuser,  // status[1:0]
    output int                             pending,
    output int                             fail_count
);

    timeunit 1ns;
    timeprecision 1ps;

    import rpt_pkg::*;

    localparam int ENTRIES    = 1 << INDEX_BITS;
    localparam int SLOTS      = FRAME_COUNT * ENTRIES;
    localparam int PAGE_SHIFT = 12;

    // Shadow of the table memory and the allocator
    logic [63:0]       page_ram [SLOTS];
    int                alloc_cursor;
    logic [ROOT_W-1:0] root_sel;

    // Predicted results, oldest first
    result_t walk_results_q [$];

    initial fail_count = 0;

    // Index into the frame of one level, top level first
    function automatic int level_slot(input logic [VPN_W-1:0] vpn, input int lvl);
        logic [VPN_W-1:0] shifted;
        shifted = vpn >> (INDEX_BITS * (LEVELS - 1 - lvl));
        return int'(shifted[INDEX_BITS-1:0]);
    endfunction

    // Frame named by an intermediate entry; FRAME_COUNT when absent or out of range
    function automatic int link_frame(input logic [63:0] entry);
        logic [63:0] f;
        if (entry == 64'd0)
            return FRAME_COUNT;
        f = entry >> PAGE_SHIFT;
        if (f >= 64'(FRAME_COUNT))
            return FRAME_COUNT;
        return int'(f);
    endfunction

    // Hand out the next frame, skipping the root, and zero it
    function automatic int grab_frame();
        int f;
        if (alloc_cursor == int'(root_sel))
            alloc_cursor++;
        if (alloc_cursor >= FRAME_COUNT)
            return FRAME_COUNT;
        f = alloc_cursor;
        alloc_cursor++;
        for (int i = 0; i < ENTRIES; i++)
            page_ram[f * ENTRIES + i] = 64'd0;
        return f;
    endfunction

    // Follow the links down to the leaf slot; -1 when the path is broken
    function automatic int leaf_slot(input logic [VPN_W-1:0] vpn);
        int frame;
        frame = int'(root_sel);
        if (frame >= FRAME_COUNT)
            return -1;
        for (int lvl = 0; lvl < LEVELS - 1; lvl++)
        begin
            frame = link_frame(page_ram[frame * ENTRIES + level_slot(vpn, lvl)]);
            if (frame >= FRAME_COUNT)
                return -1;
        end
        return frame * ENTRIES + level_slot(vpn, LEVELS - 1);
    endfunction

    // Walk for a map, linking fresh frames where a link is missing
    function automatic logic [STATUS_W-1:0] map_page(input logic [VPN_W-1:0] vpn,
                                                     input logic [PPN_W-1:0] ppn);
        int frame;
        int addr;
        int nxt;
        frame = int'(root_sel);
        if (frame >= FRAME_COUNT)
            return STAT_NO_FRAME;
        for (int lvl = 0; lvl < LEVELS - 1; lvl++)
        begin
            addr = frame * ENTRIES + level_slot(vpn, lvl);
            nxt  = link_frame(page_ram[addr]);
            if (nxt >= FRAME_COUNT)
            begin
                nxt = grab_frame();
                if (nxt >= FRAME_COUNT)
                    return STAT_NO_FRAME;
                page_ram[addr] = (64'(nxt) << PAGE_SHIFT) | 64'd1;
            end
            frame = nxt;
        end
        page_ram[frame * ENTRIES + level_slot(vpn, LEVELS - 1)] =
            (64'(ppn) << PAGE_SHIFT) | 64'd1;
        return STAT_OK;
    endfunction

    // Predict one request and apply its effect on the shadow table
    function automatic result_t walk_request(input logic [OP_W-1:0]  op,
                                             input logic [VPN_W-1:0] vpn,
                                             input logic [PPN_W-1:0] ppn);
        result_t r;
        int      slot;
        r.status    = STAT_NO_MAP;
        r.found_ppn = '0;
        case (op)
            OP_QUERY:
            begin
                slot = leaf_slot(vpn);
                if (slot >= 0 && page_ram[slot][0])
                begin
                    r.status    = STAT_OK;
                    r.found_ppn = page_ram[slot][PAGE_SHIFT +: PPN_W];
                end
            end
            OP_MAP:
                r.status = map_page(vpn, ppn);
            OP_UNMAP:
            begin
                slot = leaf_slot(vpn);
                if (slot >= 0 && page_ram[slot][0])
                begin
                    page_ram[slot][0] = 1'b0;
                    r.status = STAT_OK;
                end
            end
            default:
                ;
        endcase
        return r;
    endfunction

    // Track configuration, predict on request transfers, compare on result transfers
    always @(posedge clk or negedge rst_n)
    begin : monitor
        result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
                page_ram[i] = 64'd0;
            alloc_cursor = 0;
            root_sel     = '0;
            walk_results_q.delete();
            pending      = 0;
        end
        else
        begin
            if (cfg_wr_en)
                root_sel = cfg_wr_data;

            // Compare first: a result never belongs to a request of the same edge
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (walk_results_q.size() == 0)
                begin
                    $display("%0t: result transfer with nothing expected, status %0d ppn 0x%0h",
                             $time, m_axis_tuser, m_axis_tdata[PPN_W-1:0]);
                    fail_count++;
                end
                else
                begin
                    want = walk_results_q.pop_front();
                    if (m_axis_tuser !== want.status)
                    begin
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, want.status, m_axis_tuser);
                        fail_count++;
                    end
                    if (m_axis_tdata[PPN_W-1:0] !== want.found_ppn)
                    begin
                        $display("%0t: found_ppn mismatch, expected 0x%0h, actual 0x%0h",
                                 $time, want.found_ppn, m_axis_tdata[PPN_W-1:0]);
                        fail_count++;
                    end
                end
            end

            if (s_axis_tvalid && s_axis_tready)
                walk_results_q.push_back(walk_request(s_axis_tuser,
                                                      s_axis_tdata[VPN_W-1:0],
                                                      s_axis_tdata[VPN_W +: PPN_W]));

            pending = walk_results_q.size();
        end
    end

endmodule

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives the page table walker with a directed opening (empty paths, full
// width fields, remaps, unmaps, the unused opcode, a root that forces a frame
// skip and a root that turns leaves into bad links) and then random phases
// over several root frames, most requests on a few shared paths. Both stream
// sides idle at random, and the result side holds off once for a long time.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import rpt_pkg::*;

    localparam int FRAME_COUNT      = 64;
    localparam int LEVELS           = 5;
    localparam int INDEX_BITS       = 9;
    localparam int CLK_PERIOD       = 10;
    localparam int RESET_CYCLES     = 8;
    localparam int LIMIT_CYCLES     = 1_000_000;
    localparam int DRAIN_CYCLES     = 50;
    localparam int PHASE_ITEMS      = 250;
    localparam int PHASE_COUNT      = 6;
    localparam int LONG_HOLD_AT     = 100;
    localparam int LONG_HOLD_CYCLES = 600;

    localparam logic [OP_W-1:0]  OP_UNUSED = 2'd3;
    localparam logic [VPN_W-1:0] VPN_MAX   = '1;
    localparam logic [PPN_W-1:0] PPN_MAX   = '1;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [ROOT_W-1:0]     cfg_wr_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;   // vpn[44:0], ppn[96:45], zero pad
    logic [OP_W-1:0]       s_axis_tuser;   // opcode[1:0]
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // found_ppn[51:0], zero pad
    logic [STATUS_W-1:0]   m_axis_tuser;   // status[1:0]
    int                    pending;
    int                    fail_count;
    int                    cycles = 0;
    int                    send_quiet = 0;
    int                    recv_quiet = 0;
    logic [VPN_W-1:0]      prefix_pool [4];

    always #(CLK_PERIOD / 2) clk = ~clk;

    radix_page_table_walker_top #(
        .FRAME_COUNT (FRAME_COUNT),
        .LEVELS      (LEVELS),
        .INDEX_BITS  (INDEX_BITS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    rpt_walk_checker #(
        .FRAME_COUNT (FRAME_COUNT),
        .LEVELS      (LEVELS),
        .INDEX_BITS  (INDEX_BITS)
    ) i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .pending       (pending),
        .fail_count    (fail_count)
    );

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Wait before the next transfer: mostly a random wait, sometimes a run of zero waits
    function automatic int draw_wait(inout int quiet_run);
        if (quiet_run > 0)
        begin
            quiet_run--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
        begin
            quiet_run = int'($urandom_range(20, 60));
            return 0;
        end
        return int'($urandom_range(0, 19));
    endfunction

    // Offer one request and hold it until the transfer
    task automatic send_request(input logic [OP_W-1:0]  op,
                                input logic [VPN_W-1:0] vpn,
                                input logic [PPN_W-1:0] ppn);
        int gap;
        gap = draw_wait(send_quiet);
        if (gap > 0)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {{(IN_DATA_W - VPN_W - PPN_W){1'b0}}, ppn, vpn};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Drop the request valid and wait until every result has come back
    task automatic drain_requests();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // Write the root frame while the walker is idle
    task automatic set_root(input logic [ROOT_W-1:0] value);
        drain_requests();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Result side: random stalls and one long hold-off
    initial
    begin : result_sink
        int stall;
        int taken;
        bit long_hold_done;
        m_axis_tready  = 1'b0;
        taken          = 0;
        long_hold_done = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = draw_wait(recv_quiet);
            if (!long_hold_done && taken == LONG_HOLD_AT)
            begin
                stall          = LONG_HOLD_CYCLES;
                long_hold_done = 1'b1;
            end
            if (stall > 0)
            begin
                @(negedge clk);
                m_axis_tready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
            taken++;
        end
    end

    // Request side: reset, directed opening, random phases, verdict
    initial
    begin : request_source
        logic [OP_W-1:0]   op;
        logic [VPN_W-1:0]  vpn;
        logic [PPN_W-1:0]  ppn;
        logic [ROOT_W-1:0] phase_root;
        int                sel;

        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_QUERY;

        // Shared upper paths; the low index is filled per request
        prefix_pool[0] = '0;
        prefix_pool[1] = VPN_MAX;
        prefix_pool[2] = VPN_W'({$urandom, $urandom});
        prefix_pool[3] = VPN_W'({$urandom, $urandom});
        for (int i = 0; i < 4; i++)
            prefix_pool[i][INDEX_BITS-1:0] = '0;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // Root 0, written while the RAM is still being cleared
        set_root('0);
        send_request(OP_QUERY, '0, '0);
        send_request(OP_UNMAP, '0, '0);
        send_request(OP_MAP, '0, '0);
        send_request(OP_QUERY, '0, '0);

        // Root ahead of the frame counter: allocation must skip it
        set_root(ROOT_W'(6));
        send_request(OP_MAP, VPN_MAX, PPN_MAX);
        send_request(OP_QUERY, VPN_MAX, '0);
        send_request(OP_QUERY, '0, '0);

        // Back to root 0: full width fields, unmap twice, unused opcode, remap
        set_root('0);
        send_request(OP_QUERY, VPN_MAX, '0);
        send_request(OP_MAP, VPN_MAX, PPN_MAX);
        send_request(OP_QUERY, VPN_MAX, '0);
        send_request(OP_UNMAP, VPN_MAX, '0);
        send_request(OP_UNMAP, VPN_MAX, '0);
        send_request(OP_QUERY, VPN_MAX, '0);
        send_request(OP_UNUSED, '0, PPN_MAX);
        send_request(OP_QUERY, '0, '0);
        send_request(OP_MAP, '0, PPN_MAX);
        send_request(OP_MAP, prefix_pool[2] | VPN_W'(5), PPN_W'({$urandom, $urandom}));
        send_request(OP_MAP, prefix_pool[3] | VPN_W'(7), PPN_W'({$urandom, $urandom}));
        send_request(OP_QUERY, prefix_pool[2] | VPN_W'(5), '0);

        // Root on the leaf table of vpn 0: its huge leaf now reads as a bad link
        set_root(ROOT_W'(4));
        send_request(OP_QUERY, '0, '0);
        send_request(OP_UNMAP, '0, '0);
        send_request(OP_MAP, '0, PPN_W'(3));

        // Random phases over several roots, extremes included
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                1:       phase_root = '1;
                3:       phase_root = ROOT_W'($urandom_range(1, 20));
                5:       phase_root = ROOT_W'($urandom_range(0, 63));
                default: phase_root = '0;
            endcase
            set_root(phase_root);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                sel = int'($urandom_range(0, 99));
                if (sel < 40)
                    op = OP_QUERY;
                else if (sel < 75)
                    op = OP_MAP;
                else if (sel < 95)
                    op = OP_UNMAP;
                else
                    op = OP_UNUSED;

                // Mostly shared paths with a narrow leaf index, the rest anywhere
                if ($urandom_range(0, 99) < 80)
                begin
                    vpn = prefix_pool[$urandom_range(0, 3)];
                    if ($urandom_range(0, 3) != 0)
                        vpn[INDEX_BITS-1:0] = INDEX_BITS'($urandom_range(0, 15));
                    else
                        vpn[INDEX_BITS-1:0] = INDEX_BITS'($urandom);
                end
                else
                    vpn = VPN_W'({$urandom, $urandom});

                sel = int'($urandom_range(0, 9));
                if (sel == 0)
                    ppn = '0;
                else if (sel == 1)
                    ppn = PPN_MAX;
                else
                    ppn = PPN_W'({$urandom, $urandom});

                send_request(op, vpn, ppn);
            end
        end

        // Let every result arrive, then watch for strays
        drain_requests();
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
